FILE: rtl/ote_pkg.sv
package ote_pkg;

    localparam int PIXEL_W           = 32;
    localparam int TILE_NUM_W        = 14;
    localparam int POS_W             = 4;
    localparam int CFG_W             = 9;
    localparam int PER_ROW_W         = 8;
    localparam int LAST_W            = 2 * PER_ROW_W;
    localparam int ROW_SEL_W         = 2;
    localparam int DEFAULT_MAX_WIDTH = 256;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(256);
    localparam logic [CFG_W-1:0] TILE_SIDE   = CFG_W'(4);
    localparam logic [POS_W-1:0] POS_LAST    = '1;

    typedef struct packed {
        logic             accept;
        logic             issue;
        logic [POS_W-1:0] elem;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic can_load;
    } status_t;

endpackage

FILE: rtl/ote_ifs.sv
interface ote_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [ote_pkg::PIXEL_W-1:0]  pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

interface ote_tile_if;
    logic                           valid;
    logic                           ready;
    logic [ote_pkg::PIXEL_W-1:0]    tile_word;
    logic [ote_pkg::TILE_NUM_W-1:0] tile_number;
    logic [ote_pkg::POS_W-1:0]      element_position;
    logic                           tile_end;
    logic                           image_end;

    modport source (output valid, output tile_word, output tile_number,
                    output element_position, output tile_end, output image_end,
                    input ready);
    modport sink   (input valid, input tile_word, input tile_number,
                    input element_position, input tile_end, input image_end,
                    output ready);
endinterface

interface ote_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ote_pkg::CFG_W-1:0]  image_width;

    modport source (output valid, output image_width, input ready);
    modport sink   (input valid, input image_width, output ready);
endinterface

FILE: rtl/ote_ctrl.sv
module ote_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ote_pkg::status_t  st,
    output ote_pkg::cmd_t     cmd
);

    typedef enum logic {
        IDLE,
        EMIT
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [ote_pkg::POS_W-1:0]  elem_reg;
    logic [ote_pkg::POS_W-1:0]  elem_next;
    logic                       accept;
    logic                       issue;

    assign in_ready = (state_reg == IDLE);
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == EMIT) && st.can_load;

    assign cmd.accept = accept;
    assign cmd.issue  = issue;
    assign cmd.elem   = elem_reg;

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (accept && st.hit)
                begin
                    state_next = EMIT;
                    elem_next  = '0;
                end
            end
            EMIT:
            begin
                if (issue)
                begin
                    elem_next = elem_reg + ote_pkg::POS_W'(1);
                    if (elem_reg == ote_pkg::POS_LAST)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            elem_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
        end
    end

endmodule

FILE: rtl/ote_dp.sv
module ote_dp #(
    parameter int MAX_WIDTH = ote_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ote_pkg::cmd_t                cmd,
    output ote_pkg::status_t             st,
    input  logic [ote_pkg::PIXEL_W-1:0]  pixel_word,
    ote_cfg_if.sink                      cfg,
    ote_tile_if.source                   tile_out
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int ADDR_W = ote_pkg::ROW_SEL_W + CW;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [ote_pkg::PIXEL_W-1:0]    store_mem [DEPTH];

    logic [ote_pkg::CFG_W-1:0]      width_reg;
    logic [CW-1:0]                  row_reg;
    logic [CW-1:0]                  row_next;
    logic [CW-1:0]                  col_reg;
    logic [CW-1:0]                  col_next;
    logic [ote_pkg::TILE_NUM_W-1:0] tile_reg;
    logic [ote_pkg::TILE_NUM_W-1:0] tile_next;
    logic [ote_pkg::TILE_NUM_W-1:0] tile_cur_reg;
    logic [ote_pkg::ROW_SEL_W-1:0]  rbase_reg;
    logic [CW-1:0]                  cbase_reg;
    logic [ote_pkg::LAST_W-1:0]     last_reg;

    logic                           s1_valid_reg;
    logic [ote_pkg::PIXEL_W-1:0]    s1_data_reg;
    logic [ote_pkg::POS_W-1:0]      s1_pos_reg;
    logic [ote_pkg::TILE_NUM_W-1:0] s1_tile_reg;

    logic                           out_valid_reg;
    logic [ote_pkg::PIXEL_W-1:0]    out_word_reg;
    logic [ote_pkg::TILE_NUM_W-1:0] out_tile_reg;
    logic [ote_pkg::POS_W-1:0]      out_pos_reg;
    logic                           out_tend_reg;
    logic                           out_iend_reg;

    logic [ote_pkg::CFG_W-1:0]      w_nz;
    logic [ote_pkg::CFG_W-1:0]      wef;
    logic [ote_pkg::PER_ROW_W-1:0]  per_row;
    logic [CW-1:0]                  r_cur;
    logic [CW-1:0]                  c_cur;
    logic                           hit;
    logic                           out_free;
    logic                           move;
    logic [ote_pkg::ROW_SEL_W-1:0]  rd_row;
    logic [CW-1:0]                  rd_col;

    assign cfg.ready = 1'b1;

    // effective width: zero reads as one, clamp at the store size
    assign w_nz = (width_reg == '0) ? ote_pkg::CFG_W'(1) : width_reg;
    assign wef  = (32'(w_nz) > 32'(MAX_WIDTH)) ? ote_pkg::CFG_W'(MAX_WIDTH) : w_nz;
    assign per_row = ote_pkg::PER_ROW_W'((wef - ote_pkg::TILE_SIDE) >> 1)
                   + ote_pkg::PER_ROW_W'(1);

    assign r_cur = (32'(row_reg) >= 32'(wef) || 32'(col_reg) >= 32'(wef)) ? '0 : row_reg;
    assign c_cur = (32'(row_reg) >= 32'(wef) || 32'(col_reg) >= 32'(wef)) ? '0 : col_reg;

    assign hit = (wef >= ote_pkg::TILE_SIDE) && (32'(r_cur) >= 32'd3)
              && (32'(c_cur) >= 32'd3) && r_cur[0] && c_cur[0];

    assign out_free = !out_valid_reg || tile_out.ready;
    assign move     = s1_valid_reg && out_free;

    assign st.hit      = hit;
    assign st.can_load = !s1_valid_reg || out_free;

    assign rd_row = rbase_reg + cmd.elem[3:2];
    assign rd_col = cbase_reg + CW'(cmd.elem[1:0]);

    always_comb
    begin
        row_next  = r_cur;
        col_next  = c_cur;
        tile_next = hit ? tile_reg + ote_pkg::TILE_NUM_W'(1) : tile_reg;
        if (32'(c_cur) + 32'd1 >= 32'(wef))
        begin
            col_next = '0;
            if (32'(r_cur) + 32'd1 >= 32'(wef))
            begin
                row_next  = '0;
                tile_next = '0;
            end
            else
            begin
                row_next = r_cur + CW'(1);
            end
        end
        else
        begin
            col_next = c_cur + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ote_pkg::WIDTH_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            tile_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                width_reg <= cfg.image_width;
                row_reg   <= '0;
                col_reg   <= '0;
                tile_reg  <= '0;
            end
            else if (cmd.accept)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                tile_reg <= tile_next;
            end

            if (cmd.issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tile_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= ote_pkg::LAST_W'({{ote_pkg::PER_ROW_W{1'b0}}, per_row}
                  * {{ote_pkg::PER_ROW_W{1'b0}}, per_row}) - ote_pkg::LAST_W'(1);

        if (cmd.accept)
        begin
            store_mem[{r_cur[1:0], c_cur}] <= pixel_word;
            if (hit)
            begin
                rbase_reg    <= r_cur[1:0] + ote_pkg::ROW_SEL_W'(1);
                cbase_reg    <= c_cur - CW'(3);
                tile_cur_reg <= tile_reg;
            end
        end

        if (cmd.issue)
        begin
            s1_data_reg <= store_mem[{rd_row, rd_col}];
            s1_pos_reg  <= cmd.elem;
            s1_tile_reg <= tile_cur_reg;
        end

        if (move)
        begin
            out_word_reg <= s1_data_reg;
            out_tile_reg <= s1_tile_reg;
            out_pos_reg  <= s1_pos_reg;
            out_tend_reg <= (s1_pos_reg == ote_pkg::POS_LAST);
            out_iend_reg <= (s1_pos_reg == ote_pkg::POS_LAST)
                         && ({{(ote_pkg::LAST_W - ote_pkg::TILE_NUM_W){1'b0}}, s1_tile_reg}
                             == last_reg);
        end
    end

    assign tile_out.valid            = out_valid_reg;
    assign tile_out.tile_word        = out_word_reg;
    assign tile_out.tile_number      = out_tile_reg;
    assign tile_out.element_position = out_pos_reg;
    assign tile_out.tile_end         = out_tend_reg;
    assign tile_out.image_end        = out_iend_reg;

endmodule

FILE: rtl/overlapping_tile_extractor_core.sv
// channel    dir  payload                                                     handshake
// cfg        in   image_width[8:0]                                            valid/ready
// pixel_in   in   pixel_word[31:0]                                            valid/ready
// tile_out   out  tile_word, tile_number, element_position, tile_end, image_end  valid/ready
//
// A pixel that completes no tile is taken with no further work. A pixel that completes a
// tile is taken, then the controller issues 16 line-store reads, one per cycle
// while the read stage can advance; the next pixel is taken after the last read.
// Read words pass the s1 and output registers to tile_out; tile_out stalls hold the reads.
// cfg is always ready. Reset: width 256, counters zero, store contents undefined.
module overlapping_tile_extractor_core #(
    parameter int MAX_WIDTH = ote_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    ote_cfg_if.sink      cfg,
    ote_pixel_if.sink    pixel_in,
    ote_tile_if.source   tile_out
);

    ote_pkg::cmd_t     cmd;
    ote_pkg::status_t  st;
    logic              in_ready;

    assign pixel_in.ready = in_ready;

    ote_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_in.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ote_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .pixel_word (pixel_in.pixel_word),
        .cfg        (cfg),
        .tile_out   (tile_out)
    );

endmodule
